// File: design/rcfd_pkg.sv
// Shared types, constants and functions for the RC frame CRC-8 channel decoder.
// No dependencies; imported by every module of the decoder.
package rcfd_pkg;

  localparam int FRAME_BYTES_DEF = 18;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int NUM_CH          = 8;
  localparam int IDX_W           = 7;
  localparam int CHAN_W          = 11;

  localparam logic [7:0]        CRC_POLY        = 8'hD5;
  localparam logic [7:0]        START_BYTE_RST  = 8'd126;
  localparam logic [CHAN_W-1:0] CHAN_BASE       = 11'd988;
  localparam logic [CHAN_W-1:0] CHAN_RST        = 11'd1500;

  typedef logic [NUM_CH-1:0][CHAN_W-1:0] chan_arr_t;

  // One command from the front to the back: a data byte to store or the end of a frame.
  typedef struct packed {
    logic             is_end;
    logic             crc_ok;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } cmd_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // The pair is big-endian; only its low 11 bits count, halved.
  function automatic logic [CHAN_W-1:0] chan_value(input logic [7:0] hi, input logic [7:0] lo);
    return CHAN_BASE + CHAN_W'({hi[2:0], lo[7:1]});
  endfunction

endpackage

// File: design/rcfd_front.sv
// Front end of the decoder: accepts bytes, tracks the frame state and the CRC.
// Depends on rcfd_pkg; pushes store and end-of-frame commands into rcfd_queue.
module rcfd_front #(
  parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [7:0]    in_byte,
  input  logic [7:0]    start_byte,
  output logic          push,
  output rcfd_pkg::cmd_t push_cmd
);
  import rcfd_pkg::*;

  typedef enum logic [3:0] {
    ST_HUNT = 4'b0001,
    ST_DATA = 4'b0010,
    ST_CRC  = 4'b0100,
    ST_END  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, idx_inc;
  logic [7:0]       crc_r, crc_nxt;
  logic             accept;
  logic             is_start;

  assign accept   = in_tvalid && in_tready;
  assign is_start = (in_byte == start_byte);
  assign idx_inc  = idx_r + IDX_W'(1);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    push      = 1'b0;
    push_cmd  = '0;
    if (accept) begin
      unique case (state_r)
        ST_HUNT: begin
          if (is_start) begin
            state_nxt = ST_DATA;
            idx_nxt   = '0;
            crc_nxt   = '0;
          end
        end
        ST_DATA: begin
          if (is_start) begin
            idx_nxt = '0;
            crc_nxt = '0;
          end else begin
            push          = 1'b1;
            push_cmd.idx  = idx_r;
            push_cmd.data = in_byte;
            crc_nxt       = crc8_update(crc_r, in_byte);
            idx_nxt       = idx_inc;
            if (idx_inc >= IDX_W'(FRAME_BYTES)) begin
              state_nxt = ST_CRC;
            end
          end
        end
        ST_CRC: begin
          push            = 1'b1;
          push_cmd.is_end = 1'b1;
          push_cmd.crc_ok = (crc_r == in_byte);
          state_nxt       = ST_END;
        end
        ST_END: begin
          if (is_start) begin
            state_nxt = ST_HUNT;
          end
        end
        default: state_nxt = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      idx_r   <= '0;
      crc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

// File: design/rcfd_queue.sv
// Short command queue between the front and the back of the decoder.
// Depends on rcfd_pkg for the command type.
module rcfd_queue #(
  parameter int DEPTH = rcfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rcfd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rcfd_pkg::cmd_t head_cmd
);
  import rcfd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign valid    = (count_r != '0);
  assign head_cmd = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/rcfd_back.sv
// Back end of the decoder: keeps the channel bytes of the frame, loads channels
// on a good CRC and holds the result beat. Depends on rcfd_pkg.
module rcfd_back #(
  parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rcfd_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic                out_crc_ok,
  output rcfd_pkg::chan_arr_t out_chans
);
  import rcfd_pkg::*;

  // Only bytes 1..16 of a frame carry channel pairs.
  localparam int STORE_N = (FRAME_BYTES - 1 < 2 * NUM_CH) ? FRAME_BYTES - 1 : 2 * NUM_CH;

  logic [7:0]        store_r [STORE_N];
  logic [CHAN_W-1:0] chan_r  [NUM_CH];
  logic              out_valid_r, out_valid_nxt;
  logic              ok_r;
  logic              store_en;
  logic              load_en;

  assign q_pop    = q_valid && (!q_cmd.is_end || !out_valid_r || out_tready);
  assign store_en = q_pop && !q_cmd.is_end;
  assign load_en  = q_pop && q_cmd.is_end && q_cmd.crc_ok;

  always_ff @(posedge clk) begin
    for (int j = 0; j < STORE_N; j++) begin
      if (store_en && (q_cmd.idx == IDX_W'(j + 1))) begin
        store_r[j] <= q_cmd.data;
      end
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chan
    if (2 * ch + 2 < FRAME_BYTES) begin : g_load
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          chan_r[ch] <= CHAN_RST;
        end else if (load_en) begin
          chan_r[ch] <= chan_value(store_r[2 * ch], store_r[2 * ch + 1]);
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          chan_r[ch] <= CHAN_RST;
        end
      end
    end
    assign out_chans[ch] = chan_r[ch];
  end

  // Channels change only when an end command pops, which needs the result register free or being read out.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop && q_cmd.is_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.is_end) begin
      ok_r <= q_cmd.crc_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_crc_ok = ok_r;

endmodule

// File: design/rc_frame_crc8_channel_decoder.sv
// RC frame decoder with CRC-8 check: one received byte per input beat.
// Throughput is one byte per cycle; the front takes a byte whenever the command queue has room.
// The result beat shows on out_tvalid once the end command has passed the command queue and the result register.
// A waiting result stalls the next end-of-frame command at the queue head and every command behind it.
// Synchronous active-low reset: hunting for a start byte, channels at 1500, start byte 126.
module rc_frame_crc8_channel_decoder #(
  parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = rcfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,   // chan0 [10:0] up to chan7 [87:77]
  output logic        out_tuser,   // [0] crc_ok
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rcfd_pkg::*;

  localparam logic REG_START_BYTE = 1'b0;

  logic      [7:0] start_byte_r;
  logic            cfg_wr;
  logic            push;
  cmd_t            push_cmd;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;
  cmd_t            q_cmd;
  chan_arr_t       chans;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_START_BYTE) ? {24'd0, start_byte_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_START_BYTE)) begin
      start_byte_r <= cfg_pwdata[7:0];
    end
  end

  assign in_tready = !q_full;

  rcfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .start_byte(start_byte_r),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rcfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_cmd(q_cmd)
  );

  rcfd_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_crc_ok(out_tuser),
    .out_chans (chans)
  );

  assign out_tdata = chans;

endmodule
